// ----- rtl/psa_pkg.sv -----
// shared types and constants of the proportional share allocator
package psa_pkg;

    localparam int UNIT_W   = 10;
    localparam int LABEL_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ADD_LATCH,
        OP_ADD_WR,
        OP_FIN_START,
        OP_PTR_INC,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SH_WR,
        OP_SCAN_START,
        OP_SCAN_CMP,
        OP_DEC_WR,
        OP_EMIT_START,
        OP_OUT_OK,
        OP_OUT_ERR,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t                op;
        logic [STATUS_W-1:0]   err_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic total_zero;
        logic too_many;
        logic ptr_valid;
        logic ptr_last;
        logic div_done;
        logic sum_gt;
        logic found;
        logic out_last;
    } dp_stat_t;

endpackage

// ----- rtl/psa_datapath.sv -----
// count and share stores, multiplier, ceiling divider and result register
module psa_datapath #(
    parameter int MAX_CLUSTERS = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [psa_pkg::UNIT_W-1:0]    cfg_wdata,
    input  logic [psa_pkg::LABEL_W-1:0]   in_label,
    input  psa_pkg::ctrl_cmd_t            cmd,
    output psa_pkg::dp_stat_t             stat,
    output logic [psa_pkg::LABEL_W-1:0]   out_label,
    output logic [psa_pkg::UNIT_W-1:0]    out_share,
    output logic [psa_pkg::STATUS_W-1:0]  out_status,
    output logic                          out_last
);
    import psa_pkg::*;

    localparam int AW  = $clog2(MAX_CLUSTERS);
    localparam int PRW = $clog2(MAX_CLUSTERS + 1);
    localparam int PW  = COUNT_BITS + UNIT_W;
    localparam int DW  = PW + 1;
    localparam int BCW = $clog2(DW);
    localparam int SW  = UNIT_W + PRW;

    logic [COUNT_BITS-1:0]   count_mem [MAX_CLUSTERS];
    logic [UNIT_W-1:0]       share_mem [MAX_CLUSTERS];

    logic [MAX_CLUSTERS-1:0] valid_reg;
    logic [PRW-1:0]          present_reg;
    logic [COUNT_BITS-1:0]   item_total_reg;
    logic [UNIT_W-1:0]       tu_reg;

    logic [AW-1:0]           ptr_reg;
    logic                    add_ok_reg;
    logic [COUNT_BITS-1:0]   cnt_rd_reg;
    logic [UNIT_W-1:0]       shr_rd_reg;
    logic [PW-1:0]           prod_reg;
    logic [DW-1:0]           dvd_reg;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [UNIT_W-1:0]       quo_reg;
    logic [BCW-1:0]          bitcnt_reg;
    logic [SW-1:0]           sum_reg;
    logic                    found_reg;
    logic [UNIT_W-1:0]       min_reg;
    logic [AW-1:0]           pick_reg;
    logic [PRW-1:0]          emit_reg;
    logic [LABEL_W-1:0]      out_label_reg;
    logic [UNIT_W-1:0]       out_share_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic                    out_last_reg;

    logic [31:0]             lab32;
    logic [31:0]             ptr32;
    logic                    ptr_last;
    logic [COUNT_BITS:0]     rem_sh;
    logic [COUNT_BITS:0]     rem_sub;
    logic                    rem_ge;
    logic                    cand;
    logic                    emit_last;
    logic                    sh_we;
    logic [AW-1:0]           sh_wa;
    logic [UNIT_W-1:0]       sh_wd;

    assign lab32     = 32'(in_label);
    assign ptr32     = 32'(ptr_reg);
    assign ptr_last  = (ptr_reg == AW'(MAX_CLUSTERS - 1));
    assign rem_sh    = {rem_reg, dvd_reg[DW-1]};
    assign rem_sub   = rem_sh - {1'b0, item_total_reg};
    assign rem_ge    = (rem_sh >= {1'b0, item_total_reg});
    assign cand      = valid_reg[ptr_reg] && (shr_rd_reg > UNIT_W'(1))
                       && (!found_reg || (shr_rd_reg < min_reg));
    assign emit_last = ((emit_reg + PRW'(1)) == present_reg);

    always_comb begin
        sh_we = 1'b0;
        sh_wa = ptr_reg;
        sh_wd = quo_reg;
        if (cmd.op == OP_SH_WR) begin
            sh_we = 1'b1;
        end else if (cmd.op == OP_DEC_WR) begin
            sh_we = 1'b1;
            sh_wa = pick_reg;
            sh_wd = min_reg - UNIT_W'(1);
        end
    end

    // stores: read every cycle at the pointer, registered read data
    always_ff @(posedge aclk) begin
        cnt_rd_reg <= count_mem[ptr_reg];
        shr_rd_reg <= share_mem[ptr_reg];
        if (cmd.op == OP_ADD_WR && add_ok_reg) begin
            count_mem[ptr_reg] <= valid_reg[ptr_reg] ? cnt_rd_reg + COUNT_BITS'(1)
                                                      : COUNT_BITS'(1);
        end
        if (sh_we) begin
            share_mem[sh_wa] <= sh_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            present_reg    <= '0;
            item_total_reg <= '0;
            tu_reg         <= UNIT_W'(16);
        end else begin
            if (cfg_we) begin
                tu_reg <= cfg_wdata;
            end
            if (cmd.op == OP_ADD_WR && add_ok_reg) begin
                valid_reg[ptr_reg] <= 1'b1;
                if (!valid_reg[ptr_reg]) begin
                    present_reg <= present_reg + PRW'(1);
                end
                item_total_reg <= item_total_reg + COUNT_BITS'(1);
            end else if (cmd.op == OP_CLEAR) begin
                valid_reg      <= '0;
                present_reg    <= '0;
                item_total_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ADD_LATCH: begin
                ptr_reg    <= lab32[AW-1:0];
                add_ok_reg <= (lab32 < 32'(MAX_CLUSTERS)) && (item_total_reg != '1);
            end
            OP_FIN_START: begin
                ptr_reg <= '0;
                sum_reg <= '0;
            end
            OP_PTR_INC: begin
                if (!ptr_last) ptr_reg <= ptr_reg + AW'(1);
            end
            OP_MUL: begin
                prod_reg <= PW'(tu_reg) * PW'(cnt_rd_reg);
            end
            OP_DIV_INIT: begin
                // ceiling division: divide count*units + total - 1 by total
                dvd_reg    <= DW'(prod_reg) + DW'(item_total_reg) - DW'(1);
                rem_reg    <= '0;
                quo_reg    <= '0;
                bitcnt_reg <= BCW'(DW - 1);
            end
            OP_DIV_STEP: begin
                dvd_reg    <= dvd_reg << 1;
                bitcnt_reg <= bitcnt_reg - BCW'(1);
                rem_reg    <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
                quo_reg    <= {quo_reg[UNIT_W-2:0], rem_ge};
            end
            OP_SH_WR: begin
                sum_reg <= sum_reg + SW'(quo_reg);
                if (!ptr_last) ptr_reg <= ptr_reg + AW'(1);
            end
            OP_SCAN_START: begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            OP_SCAN_CMP: begin
                if (cand) begin
                    found_reg <= 1'b1;
                    min_reg   <= shr_rd_reg;
                    pick_reg  <= ptr_reg;
                end
                if (!ptr_last) ptr_reg <= ptr_reg + AW'(1);
            end
            OP_DEC_WR: begin
                sum_reg <= sum_reg - SW'(1);
            end
            OP_EMIT_START: begin
                ptr_reg  <= '0;
                emit_reg <= '0;
            end
            OP_OUT_OK: begin
                out_label_reg  <= ptr32[LABEL_W-1:0];
                out_share_reg  <= shr_rd_reg;
                out_status_reg <= ST_OK;
                out_last_reg   <= emit_last;
                emit_reg       <= emit_reg + PRW'(1);
            end
            OP_OUT_ERR: begin
                out_label_reg  <= '0;
                out_share_reg  <= '0;
                out_status_reg <= cmd.err_status;
                out_last_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.total_zero = (item_total_reg == '0);
    assign stat.too_many   = (32'(present_reg) > 32'(tu_reg));
    assign stat.ptr_valid  = valid_reg[ptr_reg];
    assign stat.ptr_last   = ptr_last;
    assign stat.div_done   = (bitcnt_reg == '0);
    assign stat.sum_gt     = (sum_reg > SW'(tu_reg));
    assign stat.found      = found_reg;
    assign stat.out_last   = out_last_reg;

    assign out_label  = out_label_reg;
    assign out_share  = out_share_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- rtl/psa_ctrl.sv -----
// sequencer for loads, share computation, reduction and result delivery
module psa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_cmd,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  psa_pkg::dp_stat_t   stat,
    output psa_pkg::ctrl_cmd_t  cmd
);
    import psa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_A_WAIT, S_A_WR,
        S_C_CHK, S_C_MUL, S_C_DINIT, S_C_DIV, S_C_WR,
        S_R_CHK, S_R_SA, S_R_SB, S_R_DEC,
        S_O_CHK, S_O_LOAD, S_O_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    always_comb begin
        state_next     = state_reg;
        mv_next        = mv_reg;
        cmd.op         = OP_NONE;
        cmd.err_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_cmd == CMD_ADD) begin
                        cmd.op     = OP_ADD_LATCH;
                        state_next = S_A_WAIT;
                    end else if (stat.total_zero || stat.too_many) begin
                        cmd.op         = OP_OUT_ERR;
                        cmd.err_status = stat.total_zero ? ST_EMPTY : ST_OVER;
                        mv_next        = 1'b1;
                        state_next     = S_O_WAIT;
                    end else begin
                        cmd.op     = OP_FIN_START;
                        state_next = S_C_CHK;
                    end
                end
            end
            S_A_WAIT: state_next = S_A_WR;
            S_A_WR: begin
                cmd.op     = OP_ADD_WR;
                state_next = S_IDLE;
            end
            S_C_CHK: begin
                if (stat.ptr_valid) begin
                    state_next = S_C_MUL;
                end else if (stat.ptr_last) begin
                    state_next = S_R_CHK;
                end else begin
                    cmd.op = OP_PTR_INC;
                end
            end
            S_C_MUL: begin
                cmd.op     = OP_MUL;
                state_next = S_C_DINIT;
            end
            S_C_DINIT: begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_C_DIV;
            end
            S_C_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_done) state_next = S_C_WR;
            end
            S_C_WR: begin
                cmd.op     = OP_SH_WR;
                state_next = stat.ptr_last ? S_R_CHK : S_C_CHK;
            end
            S_R_CHK: begin
                if (stat.sum_gt) begin
                    cmd.op     = OP_SCAN_START;
                    state_next = S_R_SA;
                end else begin
                    cmd.op     = OP_EMIT_START;
                    state_next = S_O_CHK;
                end
            end
            S_R_SA: state_next = S_R_SB;
            S_R_SB: begin
                cmd.op     = OP_SCAN_CMP;
                state_next = stat.ptr_last ? S_R_DEC : S_R_SA;
            end
            S_R_DEC: begin
                if (stat.found) begin
                    cmd.op     = OP_DEC_WR;
                    state_next = S_R_CHK;
                end else begin
                    cmd.op     = OP_EMIT_START;
                    state_next = S_O_CHK;
                end
            end
            S_O_CHK: begin
                if (stat.ptr_valid) begin
                    state_next = S_O_LOAD;
                end else if (stat.ptr_last) begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_IDLE;
                end else begin
                    cmd.op = OP_PTR_INC;
                end
            end
            S_O_LOAD: begin
                cmd.op     = OP_OUT_OK;
                mv_next    = 1'b1;
                state_next = S_O_WAIT;
            end
            S_O_WAIT: begin
                if (m_tready) begin
                    mv_next = 1'b0;
                    if (stat.out_last) begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_IDLE;
                    end else begin
                        cmd.op     = OP_PTR_INC;
                        state_next = S_O_CHK;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;

endmodule

// ----- rtl/proportional_share_allocator_core.sv -----
// top level of the proportional share allocator
// Each add transaction bumps the count of its cluster label unless the item
// total is saturated. A finish transaction apportions total_units among the
// present clusters by ceil(total_units*count/items): an empty table entry is
// skipped, a present one is multiplied, divided by the bit-serial ceiling
// divider and written to the share store. Each unit taken back to reach the
// total costs one scan of the share store. Results then leave one per present
// cluster in label order; a finish with no items or more present clusters than
// units gives a single error result instead. No input is taken until the last
// result is accepted.
module proportional_share_allocator_core #(
    parameter int MAX_CLUSTERS = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [psa_pkg::UNIT_W-1:0]   cfg_wdata,  // total_units
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // label[3:0], zero pad
    input  logic [0:0]                   s_tuser,    // cmd[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,    // cluster_label[3:0], share[13:4], status[15:14]
    output logic                         m_tlast
);
    import psa_pkg::*;

    ctrl_cmd_t            cmd;
    dp_stat_t             stat;
    logic [LABEL_W-1:0]   out_label;
    logic [UNIT_W-1:0]    out_share;
    logic [STATUS_W-1:0]  out_status;

    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    psa_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_label   (s_tdata[LABEL_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_label  (out_label),
        .out_share  (out_share),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {out_status, out_share, out_label};

    // input side is closed while any result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] != ST_OK) |-> (m_tlast && m_tdata[13:4] == '0))
        else $error("error result not single and zero");

    a_ok_share: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15:14] == ST_OK) |-> (m_tdata[13:4] != '0))
        else $error("present cluster got zero share");

endmodule

// ----- test/proportional_share_allocator_core_tb.sv -----
// testbench of the proportional share allocator: random label loads and finishes checked against a predictor
`timescale 1ns / 100ps

module proportional_share_allocator_core_tb;
    import psa_pkg::*;

    localparam int NCL       = 16;
    localparam int CYC_LIMIT = 2000000;

    typedef struct packed {
        logic               cmd;
        logic [LABEL_W-1:0] label;
    } load_t;

    typedef struct packed {
        logic [LABEL_W-1:0]  cluster_label;
        logic [UNIT_W-1:0]   share;
        logic [STATUS_W-1:0] status;
        logic                last;
    } share_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [UNIT_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic m_tlast;

    proportional_share_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    load_t  pending_loads[$];
    share_t expected_shares[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     error_count = 0;
    int     cycle_count = 0;

    // predictor state
    logic [UNIT_W-1:0] units_cfg = 10'd16;
    logic [15:0]       label_count[NCL];
    logic [15:0]       items_seen = '0;

    task automatic queue_load(load_t ld);
        pending_loads.insert(pending_loads.size(), ld);
    endtask

    task automatic queue_expect(share_t s);
        expected_shares.insert(expected_shares.size(), s);
    endtask

    task automatic apportion_shares();
        int present;
        longint sum;
        longint shr[NCL];
        int pick;
        present = 0;
        sum = 0;
        if (items_seen == 0) begin
            queue_expect('{4'd0, 10'd0, ST_EMPTY, 1'b1});
            return;
        end
        for (int i = 0; i < NCL; i++) if (label_count[i] != 0) present++;
        if (present > units_cfg) begin
            queue_expect('{4'd0, 10'd0, ST_OVER, 1'b1});
        end else begin
            for (int i = 0; i < NCL; i++) begin
                shr[i] = 0;
                if (label_count[i] != 0) begin
                    shr[i] = (longint'(units_cfg) * label_count[i] + items_seen - 1) / items_seen;
                    sum += shr[i];
                end
            end
            while (sum > units_cfg) begin
                pick = -1;
                for (int i = 0; i < NCL; i++)
                    if (label_count[i] != 0 && shr[i] > 1)
                        if (pick < 0 || shr[i] < shr[pick]) pick = i;
                if (pick < 0) break;
                shr[pick]--;
                sum--;
            end
            for (int i = 0; i < NCL; i++)
                if (label_count[i] != 0)
                    queue_expect('{i[3:0], shr[i][9:0], ST_OK, 1'b0});
            expected_shares[$].last = 1'b1;
        end
        for (int i = 0; i < NCL; i++) label_count[i] = '0;
        items_seen = '0;
    endtask

    task automatic predict_load(load_t ld);
        if (ld.cmd == CMD_FINISH) begin
            apportion_shares();
        end else if (items_seen != 16'hFFFF) begin
            label_count[ld.label]++;
            items_seen++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_load(load_t'({s_tuser[0], s_tdata[3:0]}));
            if ((!s_tvalid || s_tready) ) begin
                if (pending_loads.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    load_t ld;
                    ld = pending_loads.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= ld.cmd;
                    s_tdata <= {4'd0, ld.label};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_shares.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                error_count = error_count + 1;
            end else begin
                share_t e;
                e = expected_shares.pop_front();
                if (m_tdata[3:0] !== e.cluster_label) begin
                    $error("cluster_label exp %0d got %0d", e.cluster_label, m_tdata[3:0]);
                    error_count = error_count + 1;
                end
                if (m_tdata[13:4] !== e.share) begin
                    $error("share exp %0d got %0d", e.share, m_tdata[13:4]);
                    error_count = error_count + 1;
                end
                if (m_tdata[15:14] !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_tdata[15:14]);
                    error_count = error_count + 1;
                end
                if (m_tlast !== e.last) begin
                    $error("last exp %0d got %0d", e.last, m_tlast);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYC_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_loads.size() > 0 || s_tvalid || expected_shares.size() > 0)
            @(posedge aclk);
        // finish ends with a store clear after the last result
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_units(logic [UNIT_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        units_cfg = v;
    endtask

    task automatic queue_run(int n, int span);
        for (int i = 0; i < n; i++)
            queue_load('{CMD_ADD, LABEL_W'($urandom_range(span - 1))});
        queue_load('{CMD_FINISH, LABEL_W'($urandom)});
    endtask

    task automatic random_phase(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            if ($urandom_range(9) == 0) len = 0;
            queue_run(len, $urandom_range(1, NCL));
            sent += len + 1;
        end
    endtask

    initial begin
        logic [UNIT_W-1:0] units_pick[6];
        units_pick = '{10'd1023, 10'd1, 10'd5, 10'd100, 10'd3, 10'd777};
        for (int i = 0; i < NCL; i++) label_count[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty finish, extremes of labels, default total
        send_idle_pct = 23;
        recv_idle_pct = 56;
        queue_load('{CMD_FINISH, 4'hF});
        queue_load('{CMD_ADD, 4'h0});
        queue_load('{CMD_ADD, 4'hF});
        queue_load('{CMD_ADD, 4'hF});
        queue_load('{CMD_FINISH, 4'h0});
        for (int i = 0; i < NCL; i++) queue_load('{CMD_ADD, i[3:0]});
        queue_load('{CMD_FINISH, 4'hA});
        wait_drained();
        write_units(10'd2);
        // more clusters than units
        for (int i = 0; i < 3; i++) queue_load('{CMD_ADD, LABEL_W'(i * 5)});
        queue_load('{CMD_FINISH, 4'h5});
        queue_load('{CMD_FINISH, 4'h0});
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 56;
                recv_idle_pct = 23;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_units(units_pick[p]);
            random_phase(52);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/psa_pkg.sv
rtl/psa_datapath.sv
rtl/psa_ctrl.sv
rtl/proportional_share_allocator_core.sv
test/proportional_share_allocator_core_tb.sv
